FILE: rtl/vwd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the vertex weld dedup unit.
// No dependencies; imported by the controller, datapath and top level.
package vwd_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int INDEX_WIDTH = 10;
   localparam int TOL_WIDTH   = 16;
   localparam int VEC_WIDTH   = 3 * COORD_WIDTH;

   typedef struct packed {
      logic                          first_of_set;
      logic signed [COORD_WIDTH-1:0] coord_x;
      logic signed [COORD_WIDTH-1:0] coord_y;
      logic signed [COORD_WIDTH-1:0] coord_z;
   } vwd_req_type;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0] unique_index;
      logic                   is_new;
      logic                   overflow;
   } vwd_rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic issue;
      logic post_hit;
      logic post_miss;
   } vwd_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic more;
      logic cmp_valid;
      logic match;
   } vwd_stat_type;

endpackage

FILE: rtl/vwd_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine for the vertex weld dedup unit.
// Depends on vwd_pkg for the command and status structs.
module vwd_ctrl
   import vwd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  vwd_stat_type stat,
   output vwd_cmd_type  cmd
);

   localparam logic [0:0] ST_IDLE = 1'b0;
   localparam logic [0:0] ST_SCAN = 1'b1;

   logic [0:0] state_ff;
   logic [0:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.match) begin
               cmd.post_hit = 1'b1;
               state_in     = ST_IDLE;
            end else if (!stat.more && !stat.cmp_valid) begin
               cmd.post_miss = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.issue = stat.more;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

FILE: rtl/vwd_datapath.sv
`timescale 1ns / 1ps
// Datapath: unique vector table, scan address/compare pipeline, result register.
// Depends on vwd_pkg; driven by vwd_ctrl through command/status structs.
module vwd_datapath
   import vwd_pkg::*;
#(
   parameter int MAX_UNIQUE = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  vwd_cmd_type          cmd,
   output vwd_stat_type         stat,
   input  vwd_req_type          req,
   input  logic [TOL_WIDTH-1:0] tolerance,
   output logic                 rsp_valid,
   output vwd_rsp_type          rsp
);

   localparam int IDX_W = (MAX_UNIQUE > 1) ? $clog2(MAX_UNIQUE) : 1;
   localparam int CNT_W = $clog2(MAX_UNIQUE + 1);
   localparam logic [COORD_WIDTH-1:0] SIGN_BIT = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   function automatic logic axis_close(input logic [COORD_WIDTH-1:0] a,
                                       input logic [COORD_WIDTH-1:0] b,
                                       input logic [TOL_WIDTH-1:0]   tol);
      logic [COORD_WIDTH-1:0] d;
      d = (a >= b) ? (a - b) : (b - a);
      return d < COORD_WIDTH'(tol);
   endfunction

   logic [VEC_WIDTH-1:0] mem [0:MAX_UNIQUE-1];

   logic [VEC_WIDTH-1:0] vec_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     rd_addr_ff;
   logic [VEC_WIDTH-1:0] rd_data_ff;
   logic                 cmp_valid_ff;
   logic [IDX_W-1:0]     cmp_addr_ff;
   logic                 rsp_valid_ff;
   vwd_rsp_type          rsp_ff;
   logic                 full;
   logic                 close_all;

   // stored in offset-binary so unsigned compare gives signed order
   assign full = (count_ff == CNT_W'(MAX_UNIQUE));
   assign close_all =
      axis_close(rd_data_ff[3*COORD_WIDTH-1:2*COORD_WIDTH],
                 vec_ff[3*COORD_WIDTH-1:2*COORD_WIDTH], tolerance) &&
      axis_close(rd_data_ff[2*COORD_WIDTH-1:COORD_WIDTH],
                 vec_ff[2*COORD_WIDTH-1:COORD_WIDTH], tolerance) &&
      axis_close(rd_data_ff[COORD_WIDTH-1:0], vec_ff[COORD_WIDTH-1:0], tolerance);

   assign stat.more      = (rd_addr_ff < count_ff);
   assign stat.cmp_valid = cmp_valid_ff;
   assign stat.match     = cmp_valid_ff && close_all;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         vec_ff <= {req.coord_x ^ SIGN_BIT, req.coord_y ^ SIGN_BIT, req.coord_z ^ SIGN_BIT};
      end
      if (cmd.issue) begin
         rd_data_ff  <= mem[rd_addr_ff[IDX_W-1:0]];
         cmp_addr_ff <= rd_addr_ff[IDX_W-1:0];
      end
      if (cmd.post_miss && !full) begin
         mem[count_ff[IDX_W-1:0]] <= vec_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_addr_ff   <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmp_valid_ff <= cmd.issue;
         rsp_valid_ff <= cmd.post_hit || cmd.post_miss;
         if (cmd.load) begin
            rd_addr_ff <= '0;
            if (req.first_of_set) begin
               count_ff <= '0;
            end
         end else if (cmd.issue) begin
            rd_addr_ff <= rd_addr_ff + 1'b1;
         end
         if (cmd.post_miss && !full) begin
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.post_hit) begin
         rsp_ff.unique_index <= INDEX_WIDTH'(cmp_addr_ff);
         rsp_ff.is_new       <= 1'b0;
         rsp_ff.overflow     <= 1'b0;
      end else if (cmd.post_miss) begin
         rsp_ff.unique_index <= full ? '0 : INDEX_WIDTH'(count_ff);
         rsp_ff.is_new       <= !full;
         rsp_ff.overflow     <= full;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_UNIQUE))
      else $error("entry count above table depth");
   a_issue_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> rd_addr_ff < count_ff)
      else $error("read issued past stored entries");
   a_one_post: assert property (@(posedge clock) disable iff (reset)
      !(cmd.post_hit && cmd.post_miss))
      else $error("hit and miss posted together");
   a_rsp_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.is_new && rsp_ff.overflow))
      else $error("result both new and overflow");
   a_no_issue_after_post: assert property (@(posedge clock) disable iff (reset)
      (cmd.post_hit || cmd.post_miss) |=> !cmd.issue)
      else $error("read issued after result posted");
`endif

endmodule

FILE: rtl/vertex_weld_dedup_unit.sv
`timescale 1ns / 1ps
// Vertex weld dedup unit: top level with the tolerance register and APB port.
// Depends on vwd_pkg, vwd_ctrl and vwd_datapath.
//
// Usage:
//   A request (first_of_set plus a Q16.16 x/y/z vector) is taken at the clock
//   edge where start is high and busy is low. The unit then scans its table
//   of unique vectors one entry per cycle through a registered memory read
//   port and returns one result: the index of the first entry within the
//   tolerance on every axis, or the index of a newly appended entry, or the
//   overflow flag when the table is full and nothing matched.
//   The request is registered, each entry is read into a register and compared,
//   then the result is registered; a miss reads all stored entries, a hit ends the scan.
//   The single table read port sets the rate, one entry per cycle.
//   busy falls in the cycle the result is shown, so the next request can be
//   accepted then. rsp_valid is high for exactly one cycle; the receiver
//   cannot stall it.
//   Reset empties the table (no clearing pass) and loads tolerance 7.
//   The tolerance register sits at byte address 0 and should be written
//   only while busy is low.
module vertex_weld_dedup_unit
   import vwd_pkg::*;
#(
   parameter int MAX_UNIQUE = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  vwd_req_type req_data,
   output logic        rsp_valid,
   output vwd_rsp_type rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(7);

   logic [TOL_WIDTH-1:0] tolerance_ff;
   logic                 csr_write;
   vwd_cmd_type          cmd;
   vwd_stat_type         stat;
   logic                 ctrl_busy;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign prdata    = (paddr == 2'b00) ? 32'(tolerance_ff) : 32'(tolerance_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= TOL_RESET;
      end else if (csr_write) begin
         tolerance_ff <= pwdata[TOL_WIDTH-1:0];
      end
   end

   vwd_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (ctrl_busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   vwd_datapath #(
      .MAX_UNIQUE (MAX_UNIQUE)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req       (req_data),
      .tolerance (tolerance_ff),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

   assign busy = ctrl_busy;

endmodule
